>>> design/two_level_feedback_scheduler_top_macros.svh
// assertion helpers for the scheduler
`ifndef TWO_LEVEL_FEEDBACK_SCHEDULER_TOP_MACROS_SVH
`define TWO_LEVEL_FEEDBACK_SCHEDULER_TOP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define TLFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication outside reset
`define TLFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

>>> design/tlfs_pkg.sv
`timescale 1ns / 1ps
package tlfs_pkg;
  localparam int TASK_SLOTS_DEF = 8;

  localparam logic [1:0] CFG_QUANTUM = 2'd0;
  localparam logic [1:0] CFG_DISK    = 2'd1;
  localparam logic [1:0] CFG_TAPE    = 2'd2;
  localparam logic [1:0] CFG_PRINTER = 2'd3;

  localparam logic [2:0] EV_ADMIT   = 3'd0;
  localparam logic [2:0] EV_REJECT  = 3'd1;
  localparam logic [2:0] EV_NONE    = 3'd2;
  localparam logic [2:0] EV_RAN     = 3'd3;
  localparam logic [2:0] EV_BLOCK   = 3'd4;
  localparam logic [2:0] EV_DONE    = 3'd5;
  localparam logic [2:0] EV_IDLE    = 3'd6;

  localparam logic [1:0] SE_NONE    = 2'd0;
  localparam logic [1:0] SE_DEMOTE  = 2'd1;
  localparam logic [1:0] SE_REQUEUE = 2'd2;

  localparam logic [1:0] IOQ_NONE = 2'd0;
  localparam logic [1:0] IOQ_LOW  = 2'd1;
  localparam logic [1:0] IOQ_HIGH = 2'd2;

  localparam logic [1:0] KIND_DISK = 2'd0;
  localparam logic [1:0] KIND_TAPE = 2'd1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] task_id;
    logic [7:0] work_units;
    logic [7:0] io_point;
    logic [1:0] io_kind;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] time_now;
    logic [7:0]  run_id;
    logic [1:0]  slice_end;
    logic [7:0]  io_return_id;
    logic [1:0]  io_return_queue;
    logic [15:0] turnaround;
    logic [15:0] wait_time;
    logic [7:0]  done_total;
  } out_res_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;    // capture request, read heads
    logic execute;  // compute and commit result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;
  } dp_sts_t;
endpackage

>>> design/tlfs_ctrl.sv
`timescale 1ns / 1ps
`include "two_level_feedback_scheduler_top_macros.svh"
module tlfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output tlfs_pkg::dp_cmd_t cmd,
  input  tlfs_pkg::dp_sts_t sts
);
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: if (sts.done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  assign busy        = (state_r != ST_IDLE);
  assign cmd.latch   = (state_r == ST_IDLE) && start;
  assign cmd.execute = (state_r == ST_EXEC);

  `TLFS_ASSERT_IMP(a_onehot, 1'b1, $onehot(state_r), "state not one-hot")
  `TLFS_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request not taken")
  `TLFS_ASSERT_NEXT(a_exec_done, cmd.execute, !busy, "execute did not finish")
endmodule

>>> design/tlfs_dp.sv
`timescale 1ns / 1ps
`include "two_level_feedback_scheduler_top_macros.svh"
module tlfs_dp #(
  parameter int TASK_SLOTS = tlfs_pkg::TASK_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tlfs_pkg::dp_cmd_t  cmd,
  output tlfs_pkg::dp_sts_t  sts,
  input  tlfs_pkg::in_req_t  in_req,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [7:0]         cfg_val,
  output logic               out_strobe,
  output tlfs_pkg::out_res_t out_res
);
  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam logic [SW-1:0] LAST = SW'(TASK_SLOTS - 1);

  // config
  logic [7:0] quant_r, disk_r, tape_r, prn_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quant_r <= 8'd2; disk_r <= 8'd2; tape_r <= 8'd3; prn_r <= 8'd4;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tlfs_pkg::CFG_QUANTUM: quant_r <= cfg_val;
        tlfs_pkg::CFG_DISK:    disk_r  <= cfg_val;
        tlfs_pkg::CFG_TAPE:    tape_r  <= cfg_val;
        tlfs_pkg::CFG_PRINTER: prn_r   <= cfg_val;
        default: ;
      endcase
    end
  end

  // slot table, per-slot registers read at a few selected places
  logic [TASK_SLOTS-1:0] used_r, low_r;
  logic [7:0]  id_r   [TASK_SLOTS];
  logic [7:0]  work_r [TASK_SLOTS];
  logic [7:0]  left_r [TASK_SLOTS];
  logic [7:0]  iop_r  [TASK_SLOTS];
  logic [1:0]  kind_r [TASK_SLOTS];
  logic [7:0]  iol_r  [TASK_SLOTS];
  logic [15:0] adm_r  [TASK_SLOTS];

  // queues: 0 high, 1 low, 2 io
  logic [SW-1:0] qm_r   [3][TASK_SLOTS];
  logic [SW-1:0] head_r [3];
  logic [CW-1:0] cnt_r  [3];

  logic [15:0]   clk_r;
  logic          act_r, blk_r;
  logic [SW-1:0] sslot_r;
  logic [7:0]    sused_r, done_r;

  tlfs_pkg::in_req_t req_r;
  // stage-one captures
  logic [SW-1:0] free_r, run_r, ioh_r;
  logic          has_free_r, start_r, from_high_r, io_any_r;

  // free slot search, lowest free slot first
  logic [SW-1:0] free_c;
  logic          has_free_c;
  always_comb begin
    free_c = '0; has_free_c = 1'b0;
    for (int s = TASK_SLOTS - 1; s >= 0; s--) begin
      if (!used_r[s]) begin
        free_c = SW'(s); has_free_c = 1'b1;
      end
    end
  end

  function automatic logic [7:0] wait_of(input logic [1:0] k, input logic [7:0] d,
                                         input logic [7:0] t, input logic [7:0] p);
    if (k == tlfs_pkg::KIND_DISK) return d;
    if (k == tlfs_pkg::KIND_TAPE) return t;
    return p;
  endfunction

  function automatic logic [SW-1:0] wrap_add(input logic [SW-1:0] h, input logic [CW-1:0] c);
    logic [SW:0] x;
    x = {1'b0, h} + (SW+1)'(c);
    if (x >= (SW+1)'(TASK_SLOTS)) x = x - (SW+1)'(TASK_SLOTS);
    return x[SW-1:0];
  endfunction

  // execute-stage combinational work
  logic [SW-1:0] s_c;
  logic [7:0]    left_dec;
  logic          act_c;
  logic [7:0]    lim;
  logic [15:0]   clk_n, ta;
  logic          io_ret, run_done, run_blk, expire;
  logic [7:0]    sused_n;
  tlfs_pkg::out_res_t res_c;

  always_comb begin
    lim     = (quant_r == 8'd0) ? 8'd1 : quant_r;
    clk_n   = clk_r + 16'd1;
    act_c   = act_r || start_r;
    s_c     = act_r ? sslot_r : run_r;
    io_ret  = io_any_r && (iol_r[ioh_r] <= 8'd1);
    left_dec = (left_r[s_c] != 8'd0) ? left_r[s_c] - 8'd1 : 8'd0;
    ta      = clk_n - adm_r[s_c];
    sused_n = act_r ? sused_r + 8'd1 : 8'd1;
    run_done = act_c && !(act_r && blk_r) && (left_dec == 8'd0);
    run_blk  = act_c && !(act_r && blk_r) && !run_done &&
               ((work_r[s_c] - left_dec) == iop_r[s_c]);
    expire   = act_c && !run_done && (sused_n >= lim);
    res_c = '0;
    res_c.time_now = clk_n;
    if (io_ret) begin
      res_c.io_return_id    = id_r[ioh_r];
      res_c.io_return_queue = (kind_r[ioh_r] == tlfs_pkg::KIND_DISK) ?
                              tlfs_pkg::IOQ_LOW : tlfs_pkg::IOQ_HIGH;
    end
    if (!act_c) res_c.event_res = tlfs_pkg::EV_NONE;
    else begin
      res_c.run_id = id_r[s_c];
      if (act_r && blk_r) res_c.event_res = tlfs_pkg::EV_IDLE;
      else if (run_done) begin
        res_c.event_res  = tlfs_pkg::EV_DONE;
        res_c.turnaround = ta;
        res_c.wait_time  = ta - {8'd0, work_r[s_c]};
      end else if (run_blk) res_c.event_res = tlfs_pkg::EV_BLOCK;
      else begin
        res_c.event_res = tlfs_pkg::EV_RAN;
        if (expire) res_c.slice_end = low_r[s_c] ? tlfs_pkg::SE_REQUEUE : tlfs_pkg::SE_DEMOTE;
      end
    end
    res_c.done_total = (run_done && done_r != 8'hFF) ? done_r + 8'd1 : done_r;
  end

  // queue pointers after the pop at slice start and the io return pop
  logic [SW-1:0] hh_n, lh_n, ih_n;
  logic [CW-1:0] hc_n, lc_n, ic_n;
  always_comb begin
    hh_n = head_r[0]; hc_n = cnt_r[0];
    lh_n = head_r[1]; lc_n = cnt_r[1];
    ih_n = head_r[2]; ic_n = cnt_r[2];
    if (start_r && from_high_r) begin
      hh_n = (head_r[0] == LAST) ? '0 : head_r[0] + SW'(1); hc_n = cnt_r[0] - CW'(1);
    end else if (start_r) begin
      lh_n = (head_r[1] == LAST) ? '0 : head_r[1] + SW'(1); lc_n = cnt_r[1] - CW'(1);
    end
    if (io_ret) begin
      ih_n = (head_r[2] == LAST) ? '0 : head_r[2] + SW'(1); ic_n = cnt_r[2] - CW'(1);
    end
  end

  logic is_tick;
  assign is_tick = req_r.cmd;

  // result word, admit or tick
  tlfs_pkg::out_res_t res_nxt;
  always_comb begin
    res_nxt = res_c;
    if (!is_tick) begin
      res_nxt = '0;
      res_nxt.event_res  = (has_free_r && req_r.work_units != 8'd0) ?
                           tlfs_pkg::EV_ADMIT : tlfs_pkg::EV_REJECT;
      res_nxt.time_now   = clk_r;
      res_nxt.done_total = done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r      <= in_req;
      free_r     <= free_c;
      has_free_r <= has_free_c;
      start_r    <= !act_r && (cnt_r[0] != '0 || cnt_r[1] != '0);
      from_high_r <= (cnt_r[0] != '0);
      run_r      <= (cnt_r[0] != '0) ? qm_r[0][head_r[0]] : qm_r[1][head_r[1]];
      io_any_r   <= (cnt_r[2] != '0);
      ioh_r      <= qm_r[2][head_r[2]];
    end
  end

  // payload registers without reset
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (!is_tick) begin
        if (has_free_r && req_r.work_units != 8'd0) begin
          id_r[free_r]   <= req_r.task_id;
          work_r[free_r] <= req_r.work_units;
          left_r[free_r] <= req_r.work_units;
          iop_r[free_r]  <= req_r.io_point;
          kind_r[free_r] <= req_r.io_kind;
          iol_r[free_r]  <= wait_of(req_r.io_kind, disk_r, tape_r, prn_r);
          adm_r[free_r]  <= clk_r;
          qm_r[0][wrap_add(head_r[0], cnt_r[0])] <= free_r;
        end
      end else begin
        if (io_any_r) begin
          if (io_ret) iol_r[ioh_r] <= 8'd0;
          else iol_r[ioh_r] <= iol_r[ioh_r] - 8'd1;
        end
        if (act_c && !(act_r && blk_r)) left_r[s_c] <= left_dec;
        if (io_ret) begin
          if (kind_r[ioh_r] == tlfs_pkg::KIND_DISK) qm_r[1][wrap_add(lh_n, lc_n)] <= ioh_r;
          else qm_r[0][wrap_add(hh_n, hc_n)] <= ioh_r;
        end
        if (run_blk) qm_r[2][wrap_add(ih_n, ic_n)] <= s_c;
        if (res_c.slice_end != tlfs_pkg::SE_NONE)
          qm_r[1][wrap_add(lh_n, lc_n + CW'(io_ret && kind_r[ioh_r] == tlfs_pkg::KIND_DISK))]
            <= s_c;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0; low_r <= '0;
      for (int q = 0; q < 3; q++) begin
        head_r[q] <= '0; cnt_r[q] <= '0;
      end
      clk_r <= '0; act_r <= 1'b0; blk_r <= 1'b0; sslot_r <= '0; sused_r <= '0;
      done_r <= '0; out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.execute;
      if (cmd.execute) begin
        if (!is_tick) begin
          if (has_free_r && req_r.work_units != 8'd0) begin
            used_r[free_r] <= 1'b1; low_r[free_r] <= 1'b0;
            cnt_r[0] <= cnt_r[0] + CW'(1);
          end
        end else begin
          clk_r <= clk_n;
          done_r <= res_c.done_total;
          head_r[0] <= hh_n; head_r[1] <= lh_n; head_r[2] <= ih_n;
          cnt_r[0] <= hc_n + CW'(io_ret && kind_r[ioh_r] != tlfs_pkg::KIND_DISK);
          cnt_r[1] <= lc_n + CW'(io_ret && kind_r[ioh_r] == tlfs_pkg::KIND_DISK)
                      + CW'(res_c.slice_end != tlfs_pkg::SE_NONE);
          cnt_r[2] <= ic_n + CW'(run_blk);
          if (io_ret) low_r[ioh_r] <= (kind_r[ioh_r] == tlfs_pkg::KIND_DISK);
          if (res_c.slice_end != tlfs_pkg::SE_NONE) low_r[s_c] <= 1'b1;
          if (start_r) sslot_r <= run_r;
          if (act_c) sused_r <= sused_n;
          if (run_done) used_r[s_c] <= 1'b0;
          if (run_done || expire) begin
            act_r <= 1'b0; blk_r <= 1'b0;
          end else if (act_c) begin
            act_r <= 1'b1;
            blk_r <= (act_r && blk_r) || run_blk;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_res <= res_nxt;
    end
  end

  assign sts.done = cmd.execute;

  `TLFS_ASSERT_IMP(a_cnt_h, 1'b1, cnt_r[0] <= CW'(TASK_SLOTS), "high queue overflow")
  `TLFS_ASSERT_IMP(a_cnt_i, 1'b1, cnt_r[2] <= CW'(TASK_SLOTS), "io queue overflow")
  `TLFS_ASSERT_NEXT(a_strobe, cmd.execute, out_strobe, "result missing")
endmodule

>>> design/two_level_feedback_scheduler_top.sv
`timescale 1ns / 1ps
// Two-level feedback scheduler. Each request (admit or tick) is taken at a clock edge
// where start is high and busy low. The controller then passes through a read state
// and then computes and commits in the execute state; out_valid is high for the
// cycle after that with the result. The receiver cannot stall; the result must be
// taken in that cycle. busy drops in the same cycle the result shows, so the next
// request is taken at the edge that ends it; no new request is taken during the
// read, execute and result steps. Config writes are always ready and should be
// issued only while idle.
module two_level_feedback_scheduler_top #(
  parameter int TASK_SLOTS = tlfs_pkg::TASK_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               start,
  output logic               busy,
  input  tlfs_pkg::in_req_t  in_req,
  // result channel
  output logic               out_valid,
  output tlfs_pkg::out_res_t out_res,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  tlfs_pkg::dp_cmd_t cmd;
  tlfs_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencing
  tlfs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  // slot table, queues and result formation
  tlfs_dp #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_req(in_req),
    .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .out_strobe(out_valid), .out_res(out_res)
  );
endmodule

>>> dv/tb_two_level_feedback_scheduler_top.sv
`timescale 1ns / 1ps
module tb_two_level_feedback_scheduler_top;

  localparam int NSLOT = 8;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  tlfs_pkg::in_req_t in_req = '0;
  logic out_valid;
  tlfs_pkg::out_res_t out_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  two_level_feedback_scheduler_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // scheduler shadow state
  logic [7:0]  sh_quantum, sh_disk, sh_tape, sh_printer;
  logic        s_used [NSLOT];
  logic [7:0]  s_id [NSLOT], s_work [NSLOT], s_left [NSLOT], s_iop [NSLOT];
  logic [1:0]  s_kind [NSLOT];
  logic [7:0]  s_iol [NSLOT];
  logic        s_low [NSLOT];
  logic [15:0] s_admit [NSLOT];
  int          high_q [$], low_q [$], io_q [$];
  logic [15:0] sh_clock;
  logic        sl_active, sl_blocked;
  int          sl_slot;
  logic [7:0]  sl_used, sh_done;

  tlfs_pkg::in_req_t  pending_reqs [$];
  tlfs_pkg::out_res_t expected_res [$];
  int errors = 0;
  int mismatches = 0;
  int cycles = 0;
  bit driving_on = 1'b0;

  function automatic logic [7:0] wait_of(logic [1:0] k);
    if (k == tlfs_pkg::KIND_DISK) return sh_disk;
    if (k == tlfs_pkg::KIND_TAPE) return sh_tape;
    return sh_printer;
  endfunction

  // one request through the scheduler shadow, returns the expected result
  function automatic tlfs_pkg::out_res_t schedule_step(tlfs_pkg::in_req_t r);
    tlfs_pkg::out_res_t o;
    int fs, s, h;
    logic [7:0] lim;
    logic [15:0] ta;
    o = '0;
    fs = -1;
    if (r.cmd == 1'b0) begin
      for (int i = 0; i < NSLOT; i++)
        if (!s_used[i] && fs < 0) fs = i;
      if (fs < 0 || r.work_units == 8'd0) begin
        o.event_res = tlfs_pkg::EV_REJECT;
      end else begin
        s_used[fs] = 1'b1; s_id[fs] = r.task_id; s_work[fs] = r.work_units;
        s_left[fs] = r.work_units; s_iop[fs] = r.io_point; s_kind[fs] = r.io_kind;
        s_iol[fs] = wait_of(r.io_kind); s_low[fs] = 1'b0; s_admit[fs] = sh_clock;
        high_q.push_back(fs);
        o.event_res = tlfs_pkg::EV_ADMIT;
      end
    end else begin
      lim = (sh_quantum != 8'd0) ? sh_quantum : 8'd1;
      sh_clock++;
      // pick a new slice from the queues as they stood before this tick
      if (!sl_active) begin
        if (high_q.size() != 0) begin
          sl_slot = high_q.pop_front(); sl_active = 1'b1; sl_blocked = 1'b0; sl_used = '0;
        end else if (low_q.size() != 0) begin
          sl_slot = low_q.pop_front(); sl_active = 1'b1; sl_blocked = 1'b0; sl_used = '0;
        end
      end
      // i/o head countdown
      if (io_q.size() != 0) begin
        h = io_q[0];
        if (s_iol[h] <= 8'd1) begin
          void'(io_q.pop_front());
          s_iol[h] = '0;
          o.io_return_id = s_id[h];
          if (s_kind[h] == tlfs_pkg::KIND_DISK) begin
            s_low[h] = 1'b1; low_q.push_back(h); o.io_return_queue = tlfs_pkg::IOQ_LOW;
          end else begin
            s_low[h] = 1'b0; high_q.push_back(h); o.io_return_queue = tlfs_pkg::IOQ_HIGH;
          end
        end else begin
          s_iol[h]--;
        end
      end
      if (!sl_active) begin
        o.event_res = tlfs_pkg::EV_NONE;
      end else begin
        s = sl_slot;
        o.run_id = s_id[s];
        sl_used++;
        if (sl_blocked) begin
          o.event_res = tlfs_pkg::EV_IDLE;
        end else begin
          if (s_left[s] != 8'd0) s_left[s]--;
          if (s_left[s] == 8'd0) begin
            ta = sh_clock - s_admit[s];
            o.event_res = tlfs_pkg::EV_DONE;
            o.turnaround = ta;
            o.wait_time = ta - 16'(s_work[s]);
            s_used[s] = 1'b0;
            if (sh_done != 8'd255) sh_done++;
            sl_active = 1'b0;
          end else if (8'(s_work[s] - s_left[s]) == s_iop[s]) begin
            o.event_res = tlfs_pkg::EV_BLOCK;
            io_q.push_back(s);
            sl_blocked = 1'b1;
          end else begin
            o.event_res = tlfs_pkg::EV_RAN;
          end
        end
        // quantum expiry
        if (sl_active && sl_used >= lim) begin
          if (o.event_res == tlfs_pkg::EV_RAN) begin
            o.slice_end = s_low[s] ? tlfs_pkg::SE_REQUEUE : tlfs_pkg::SE_DEMOTE;
            s_low[s] = 1'b1;
            low_q.push_back(s);
          end
          sl_active = 1'b0; sl_blocked = 1'b0;
        end
      end
    end
    o.time_now = sh_clock;
    o.done_total = sh_done;
    return o;
  endfunction

  // driver: bursts and gaps
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (start && !busy) begin
        expected_res.push_back(schedule_step(in_req));
      end
      if (start && busy) begin
        // hold current request
      end else if (driving_on && pending_reqs.size() != 0 && gap_left == 0) begin
        start <= 1'b1;
        in_req <= pending_reqs.pop_front();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // monitor: results cannot be held off
  always @(posedge clk) begin
    tlfs_pkg::out_res_t e;
    if (rst_n && out_valid) begin
      if (expected_res.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected result %p", out_res);
        mismatches++;
      end else begin
        e = expected_res.pop_front();
        if (out_res !== e) begin
          errors++;
          if (mismatches < 10) $display("mismatch: exp %p got %p", e, out_res);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || start || expected_res.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      tlfs_pkg::CFG_QUANTUM: sh_quantum = val;
      tlfs_pkg::CFG_DISK:    sh_disk = val;
      tlfs_pkg::CFG_TAPE:    sh_tape = val;
      default:               sh_printer = val;
    endcase
  endtask

  function automatic tlfs_pkg::in_req_t mk_admit(logic [7:0] id, logic [7:0] w,
                                                 logic [7:0] p, logic [1:0] k);
    tlfs_pkg::in_req_t r;
    r.cmd = 1'b0; r.task_id = id; r.work_units = w; r.io_point = p; r.io_kind = k;
    return r;
  endfunction

  function automatic tlfs_pkg::in_req_t mk_tick();
    tlfs_pkg::in_req_t r;
    r = tlfs_pkg::in_req_t'($bits(tlfs_pkg::in_req_t)'($urandom));
    r.cmd = 1'b1;
    return r;
  endfunction

  // random phase: mostly ticks, with admits of mostly short jobs
  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3)
        pending_reqs.push_back(mk_admit(8'($urandom), ($urandom_range(0, 15) == 0) ?
          8'($urandom) : 8'($urandom_range(0, 12)), ($urandom_range(0, 9) == 0) ?
          8'($urandom) : 8'($urandom_range(0, 8)), 2'($urandom_range(0, 3))));
      else
        pending_reqs.push_back(mk_tick());
    end
  endtask

  initial begin
    sh_quantum = 8'd2; sh_disk = 8'd2; sh_tape = 8'd3; sh_printer = 8'd4;
    for (int i = 0; i < NSLOT; i++) s_used[i] = 1'b0;
    sh_clock = '0; sl_active = 1'b0; sl_blocked = 1'b0; sl_slot = 0; sl_used = '0;
    sh_done = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, zero work, every kind, full table, idle ticks
    pending_reqs.push_back(mk_tick());
    pending_reqs.push_back(mk_admit(8'd1, 8'd0, 8'd0, 2'd0));
    pending_reqs.push_back(mk_admit(8'd255, 8'd3, 8'd1, 2'd0));
    pending_reqs.push_back(mk_admit(8'd2, 8'd4, 8'd2, 2'd1));
    pending_reqs.push_back(mk_admit(8'd3, 8'd2, 8'd0, 2'd2));
    pending_reqs.push_back(mk_admit(8'd4, 8'd3, 8'd1, 2'd3));
    pending_reqs.push_back(mk_admit(8'd5, 8'd1, 8'd255, 2'd0));
    pending_reqs.push_back(mk_admit(8'd6, 8'd5, 8'd5, 2'd1));
    pending_reqs.push_back(mk_admit(8'd7, 8'd6, 8'd3, 2'd2));
    pending_reqs.push_back(mk_admit(8'd8, 8'd255, 8'd254, 2'd3));
    pending_reqs.push_back(mk_admit(8'd9, 8'd2, 8'd1, 2'd0));
    for (int i = 0; i < 14; i++) pending_reqs.push_back(mk_tick());
    driving_on = 1'b1;
    wait_drained();

    // quantum and waits at their extremes, zero included
    write_reg(tlfs_pkg::CFG_QUANTUM, 8'd1); write_reg(tlfs_pkg::CFG_DISK, 8'd0);
    write_reg(tlfs_pkg::CFG_TAPE, 8'd1);    write_reg(tlfs_pkg::CFG_PRINTER, 8'd255);
    queue_random(350);
    wait_drained();

    write_reg(tlfs_pkg::CFG_QUANTUM, 8'd0); write_reg(tlfs_pkg::CFG_DISK, 8'd255);
    write_reg(tlfs_pkg::CFG_TAPE, 8'd0);    write_reg(tlfs_pkg::CFG_PRINTER, 8'd1);
    queue_random(350);
    wait_drained();

    write_reg(tlfs_pkg::CFG_QUANTUM, 8'd255); write_reg(tlfs_pkg::CFG_DISK, 8'd1);
    write_reg(tlfs_pkg::CFG_TAPE, 8'd5);      write_reg(tlfs_pkg::CFG_PRINTER, 8'd0);
    queue_random(400);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(tlfs_pkg::CFG_QUANTUM, 8'($urandom_range(1, 6)));
      write_reg(tlfs_pkg::CFG_DISK, 8'($urandom_range(1, 6)));
      write_reg(tlfs_pkg::CFG_TAPE, 8'($urandom_range(1, 6)));
      write_reg(tlfs_pkg::CFG_PRINTER, 8'($urandom_range(1, 6)));
      queue_random(210);
      wait_drained();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
